@@ sv/awfe_pkg.sv @@
// Package for the audio window feature extractor.
// Holds the widths, limits, reset values and the queue entry types.
// No dependencies.
`timescale 1ns / 1ps

package awfe_pkg;

	localparam int MAX_WINDOW_SAMPLES = 4096;

	localparam int RAW_W   = 10;
	localparam int CEN_W   = 11;
	localparam int AMP_W   = 10;
	localparam int ADIF_W  = 11;
	localparam int THR_W   = 7;
	localparam int SUM_W   = 22;
	localparam int CNT_W   = 13;
	localparam int CROSS_W = 12;
	localparam int TOT_W   = 11;
	localparam int SHORT_W = 11;
	localparam int LONG_W  = 10;
	localparam int RUN_W   = 3;

	localparam int CNT_LIM_I = (MAX_WINDOW_SAMPLES > 8191) ? 8191 : MAX_WINDOW_SAMPLES;
	localparam logic [CNT_W-1:0] CNT_LIM = CNT_W'(CNT_LIM_I);

	localparam logic [RAW_W-1:0] MIDPOINT   = RAW_W'(512);
	localparam logic [RAW_W-1:0] MIN_RESET  = '1;
	localparam logic [THR_W-1:0] THR_RESET  = THR_W'(18);
	localparam logic [RUN_W-1:0] RUN_SAT    = RUN_W'(5);
	localparam logic [RUN_W-1:0] RUN_MIN    = RUN_W'(2);
	localparam logic [RUN_W-1:0] RUN_SHORT  = RUN_W'(4);

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic [RAW_W-1:0]        raw;
		logic signed [CEN_W-1:0] centered;
		logic [AMP_W-1:0]        amp;
		logic                    pos;
		logic                    neg;
		logic                    above;
		logic                    last;
	} awfe_entry_t;

	typedef struct packed {
		logic        push;
		awfe_entry_t data;
	} awfe_wr_t;

	typedef struct packed {
		logic        valid;
		awfe_entry_t data;
	} awfe_rd_t;

endpackage

@@ sv/audio_window_feature_extractor_core.sv @@
// Top level of the audio window feature extractor.
// Connects front end, queue and back end. Depends on awfe_pkg,
// awfe_front, awfe_queue and awfe_back.
//
// Usage:
//   Input channel (in_valid / in_stall): one 10-bit raw sample per item, with
//   last_of_window marking the final sample of an analysis window.
//   Output channel (out_valid / out_stall): one result item per window, sent
//   after the item flagged last_of_window, carrying peak-to-peak, amplitude
//   and difference sums, sample count, zero crossings and burst counts.
//   Configuration: cfg_we writes cfg_wdata into the burst threshold; write
//   only while no item is in flight.
//   Throughput: one item per cycle while in_stall is low. The edge that takes
//   the last item writes it into the queue; when the back end pops it, the
//   features move into the output register and out_valid rises.
//   Stall: while out_stall holds a result, non-last items keep draining; a
//   last item waits in the four-entry queue, and in_stall rises once the
//   queue is full.
//   Reset: arst_n clears the queue, all window state and the output valid,
//   and sets the threshold to 18. No clearing pass is needed.
`timescale 1ns / 1ps

module audio_window_feature_extractor_core import awfe_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [THR_W-1:0]   cfg_wdata,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [RAW_W-1:0]   sample,
	input  logic               last_of_window,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [RAW_W-1:0]   peak_to_peak,
	output logic [SUM_W-1:0]   amplitude_sum,
	output logic [SUM_W-1:0]   difference_sum,
	output logic [CNT_W-1:0]   sample_count,
	output logic [CROSS_W-1:0] zero_crossings,
	output logic [TOT_W-1:0]   burst_count,
	output logic [SHORT_W-1:0] short_burst_count,
	output logic [LONG_W-1:0]  long_burst_count
);

	awfe_wr_t q_wr;
	awfe_rd_t q_rd;
	logic     q_full;
	logic     q_pop;

	awfe_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.sample         (sample),
		.last_of_window (last_of_window),
		.q_full         (q_full),
		.q_wr           (q_wr)
	);

	awfe_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_wr),
		.full   (q_full),
		.pop    (q_pop),
		.rd     (q_rd)
	);

	awfe_back u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.rd                (q_rd),
		.pop               (q_pop),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.peak_to_peak      (peak_to_peak),
		.amplitude_sum     (amplitude_sum),
		.difference_sum    (difference_sum),
		.sample_count      (sample_count),
		.zero_crossings    (zero_crossings),
		.burst_count       (burst_count),
		.short_burst_count (short_burst_count),
		.long_burst_count  (long_burst_count)
	);

endmodule

@@ sv/awfe_front.sv @@
// Front end of the audio window feature extractor: input handshake,
// threshold register and per-sample classification into a queue entry.
// Depends on awfe_pkg.
`timescale 1ns / 1ps

module awfe_front import awfe_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [THR_W-1:0] cfg_wdata,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [RAW_W-1:0] sample,
	input  logic             last_of_window,
	input  logic             q_full,
	output awfe_wr_t         q_wr
);

	logic [THR_W-1:0]        thr_q;
	logic signed [CEN_W-1:0] cen;
	logic [CEN_W-1:0]        mag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (cfg_we) begin
			thr_q <= cfg_wdata;
		end
	end

	always_comb begin
		cen = $signed({1'b0, sample}) - $signed({1'b0, MIDPOINT});
		mag = cen[CEN_W-1] ? CEN_W'(-cen) : CEN_W'(cen);
	end

	assign in_stall = q_full;

	always_comb begin
		q_wr.push          = in_valid && !q_full;
		q_wr.data.raw      = sample;
		q_wr.data.centered = cen;
		q_wr.data.amp      = mag[AMP_W-1:0];
		q_wr.data.neg      = cen[CEN_W-1];
		q_wr.data.pos      = !cen[CEN_W-1] && (cen != '0);
		q_wr.data.above    = mag[AMP_W-1:0] > AMP_W'(thr_q);
		q_wr.data.last     = last_of_window;
	end

endmodule

@@ sv/awfe_queue.sv @@
// Short queue between the front end and the accumulator back end.
// Register array with read and write pointers and an occupancy count.
// Depends on awfe_pkg.
`timescale 1ns / 1ps

module awfe_queue import awfe_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  awfe_wr_t wr,
	output logic     full,
	input  logic     pop,
	output awfe_rd_t rd
);

	awfe_entry_t       mem_q [QDEPTH];
	logic [QPTR_W-1:0] wptr_q;
	logic [QPTR_W-1:0] rptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full     = (cnt_q == QCNT_W'(QDEPTH));
	assign rd.valid = (cnt_q != '0);
	assign rd.data  = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (wr.push) begin
			mem_q[wptr_q] <= wr.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (wr.push) begin
				wptr_q <= (wptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (wr.push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!wr.push && pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCNT_W'(QDEPTH))
		else $error("queue count beyond depth");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr.push && full))
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> rd.valid)
		else $error("pop from empty queue");

endmodule

@@ sv/awfe_back.sv @@
// Back end of the audio window feature extractor: window accumulators,
// crossing and burst counters, and the result output register.
// Depends on awfe_pkg.
`timescale 1ns / 1ps

module awfe_back import awfe_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  awfe_rd_t           rd,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [RAW_W-1:0]   peak_to_peak,
	output logic [SUM_W-1:0]   amplitude_sum,
	output logic [SUM_W-1:0]   difference_sum,
	output logic [CNT_W-1:0]   sample_count,
	output logic [CROSS_W-1:0] zero_crossings,
	output logic [TOT_W-1:0]   burst_count,
	output logic [SHORT_W-1:0] short_burst_count,
	output logic [LONG_W-1:0]  long_burst_count
);

	logic signed [CEN_W-1:0] prev_q;
	logic [RAW_W-1:0]        min_q, max_q;
	logic [SUM_W-1:0]        asum_q, dsum_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [CROSS_W-1:0]      cross_q;
	logic                    inside_q;
	logic [RUN_W-1:0]        run_q;
	logic [TOT_W-1:0]        tot_q;
	logic [SHORT_W-1:0]      short_q;
	logic [LONG_W-1:0]       long_q;
	logic                    ovalid_q;

	logic [RAW_W-1:0]        min_n, max_n;
	logic [SUM_W-1:0]        asum_n, dsum_n;
	logic [SUM_W:0]          asum_w, dsum_w;
	logic signed [CEN_W:0]   dif;
	logic [ADIF_W-1:0]       adif;
	logic [CNT_W-1:0]        cnt_n;
	logic [CROSS_W-1:0]      cross_n;
	logic                    inside_n;
	logic [RUN_W-1:0]        run_n;
	logic [TOT_W-1:0]        tot_n;
	logic [SHORT_W-1:0]      short_n;
	logic [LONG_W-1:0]       long_n;
	logic                    prev_pos, prev_neg;
	awfe_entry_t             e;

	assign e   = rd.data;
	assign pop = rd.valid && (!e.last || !ovalid_q || !out_stall);

	always_comb begin
		min_n  = (e.raw < min_q) ? e.raw : min_q;
		max_n  = (e.raw > max_q) ? e.raw : max_q;
		asum_w = {1'b0, asum_q} + (SUM_W + 1)'(e.amp);
		asum_n = asum_w[SUM_W] ? '1 : asum_w[SUM_W-1:0];
		dif    = (CEN_W + 1)'(e.centered) - (CEN_W + 1)'(prev_q);
		adif   = dif[CEN_W] ? ADIF_W'(-dif) : ADIF_W'(dif);
		dsum_w = {1'b0, dsum_q} + (SUM_W + 1)'(adif);
		if (cnt_q == '0) begin
			dsum_n = dsum_q;
		end else begin
			dsum_n = dsum_w[SUM_W] ? '1 : dsum_w[SUM_W-1:0];
		end
		cnt_n    = (cnt_q >= CNT_LIM) ? CNT_LIM : cnt_q + 1'b1;
		prev_neg = prev_q[CEN_W-1];
		prev_pos = !prev_q[CEN_W-1] && (prev_q != '0);
		cross_n  = cross_q;
		if (((e.pos && prev_neg) || (e.neg && prev_pos)) && (cross_q != '1)) begin
			cross_n = cross_q + 1'b1;
		end
		inside_n = inside_q;
		run_n    = run_q;
		tot_n    = tot_q;
		short_n  = short_q;
		long_n   = long_q;
		if (e.above) begin
			inside_n = 1'b1;
			if (!inside_q) begin
				run_n = RUN_W'(1);
			end else if (run_q < RUN_SAT) begin
				run_n = run_q + 1'b1;
			end
		end else if (inside_q) begin
			inside_n = 1'b0;
			run_n    = '0;
			if (run_q >= RUN_MIN) begin
				if (tot_q != '1) begin
					tot_n = tot_q + 1'b1;
				end
				if (run_q <= RUN_SHORT) begin
					if (short_q != '1) begin
						short_n = short_q + 1'b1;
					end
				end else if (long_q != '1) begin
					long_n = long_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q   <= '0;
			min_q    <= MIN_RESET;
			max_q    <= '0;
			asum_q   <= '0;
			dsum_q   <= '0;
			cnt_q    <= '0;
			cross_q  <= '0;
			inside_q <= 1'b0;
			run_q    <= '0;
			tot_q    <= '0;
			short_q  <= '0;
			long_q   <= '0;
		end else if (pop) begin
			if (e.last) begin
				prev_q   <= '0;
				min_q    <= MIN_RESET;
				max_q    <= '0;
				asum_q   <= '0;
				dsum_q   <= '0;
				cnt_q    <= '0;
				cross_q  <= '0;
				inside_q <= 1'b0;
				run_q    <= '0;
				tot_q    <= '0;
				short_q  <= '0;
				long_q   <= '0;
			end else begin
				prev_q   <= e.centered;
				min_q    <= min_n;
				max_q    <= max_n;
				asum_q   <= asum_n;
				dsum_q   <= dsum_n;
				cnt_q    <= cnt_n;
				cross_q  <= cross_n;
				inside_q <= inside_n;
				run_q    <= run_n;
				tot_q    <= tot_n;
				short_q  <= short_n;
				long_q   <= long_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (pop && e.last) begin
			ovalid_q <= 1'b1;
		end else if (!out_stall) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && e.last) begin
			peak_to_peak      <= max_n - min_n;
			amplitude_sum     <= asum_n;
			difference_sum    <= dsum_n;
			sample_count      <= cnt_n;
			zero_crossings    <= cross_n;
			burst_count       <= tot_n;
			short_burst_count <= short_n;
			long_burst_count  <= long_n;
		end
	end

	assign out_valid = ovalid_q;

	a_run_range: assert property (@(posedge clk) disable iff (!arst_n)
		run_q <= RUN_SAT)
		else $error("run length beyond saturation");

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && e.last) |=> (cnt_q == '0 && !inside_q && tot_q == '0))
		else $error("window state not cleared after last item");

	a_no_result_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && e.last) |-> (!ovalid_q || !out_stall))
		else $error("pending result overwritten");

	a_burst_split: assert property (@(posedge clk) disable iff (!arst_n)
		(tot_q != '1) |-> (TOT_W'(short_q) + TOT_W'(long_q) == tot_q))
		else $error("burst totals inconsistent");

endmodule

@@ sim/audio_window_feature_extractor_core_test.sv @@
// Self-checking testbench for audio_window_feature_extractor_core.
// Holds a feature predictor class and the top module that drives samples, the threshold and
// receiver stalls. Depends on awfe_pkg and the RTL only.
`timescale 1ns / 1ps

import awfe_pkg::*;

typedef struct {
	logic [RAW_W-1:0]   peak_to_peak;
	logic [SUM_W-1:0]   amplitude_sum;
	logic [SUM_W-1:0]   difference_sum;
	logic [CNT_W-1:0]   sample_count;
	logic [CROSS_W-1:0] zero_crossings;
	logic [TOT_W-1:0]   burst_count;
	logic [SHORT_W-1:0] short_burst_count;
	logic [LONG_W-1:0]  long_burst_count;
} window_features_t;

class window_feature_board;
	logic [THR_W-1:0]        threshold;
	logic signed [CEN_W-1:0] prev_cen;
	logic [RAW_W-1:0]        low_raw;
	logic [RAW_W-1:0]        high_raw;
	logic [SUM_W-1:0]        amp_total;
	logic [SUM_W-1:0]        diff_total;
	logic [CNT_W-1:0]        seen;
	logic [CROSS_W-1:0]      crossings;
	logic                    in_run;
	logic [RUN_W-1:0]        run_len;
	logic [TOT_W-1:0]        bursts;
	logic [SHORT_W-1:0]      short_bursts;
	logic [LONG_W-1:0]       long_bursts;
	window_features_t        pending_windows[$];
	int                      mismatch_count;

	function new();
		threshold = THR_RESET;
		mismatch_count = 0;
		open_window();
	endfunction

	function void open_window();
		prev_cen = '0;
		low_raw = MIN_RESET;
		high_raw = '0;
		amp_total = '0;
		diff_total = '0;
		seen = '0;
		crossings = '0;
		in_run = 1'b0;
		run_len = '0;
		bursts = '0;
		short_bursts = '0;
		long_bursts = '0;
	endfunction

	function int bump(int acc, int inc, int lim);
		return (acc + inc > lim) ? lim : acc + inc;
	endfunction

	function void take_sample(logic [RAW_W-1:0] raw, logic last);
		int cen;
		int mag;
		int step;
		window_features_t f;
		cen = int'(raw) - 512;
		mag = (cen < 0) ? -cen : cen;
		if (raw < low_raw)
			low_raw = raw;
		if (raw > high_raw)
			high_raw = raw;
		amp_total = SUM_W'(bump(amp_total, mag, (1 << SUM_W) - 1));
		if (seen > 0) begin
			step = cen - int'(prev_cen);
			if (step < 0)
				step = -step;
			diff_total = SUM_W'(bump(diff_total, step, (1 << SUM_W) - 1));
		end
		seen = CNT_W'(bump(seen, 1, CNT_LIM_I));
		if ((cen > 0 && prev_cen < 0) || (cen < 0 && prev_cen > 0))
			crossings = CROSS_W'(bump(crossings, 1, (1 << CROSS_W) - 1));
		if (mag > threshold) begin
			if (!in_run) begin
				in_run = 1'b1;
				run_len = '0;
			end
			if (run_len < 5)
				run_len = run_len + 1'b1;
		end else if (in_run) begin
			if (run_len >= 2) begin
				bursts = TOT_W'(bump(bursts, 1, (1 << TOT_W) - 1));
				if (run_len <= 4)
					short_bursts = SHORT_W'(bump(short_bursts, 1, (1 << SHORT_W) - 1));
				else
					long_bursts = LONG_W'(bump(long_bursts, 1, (1 << LONG_W) - 1));
			end
			in_run = 1'b0;
			run_len = '0;
		end
		prev_cen = CEN_W'(cen);
		if (last) begin
			f.peak_to_peak = high_raw - low_raw;
			f.amplitude_sum = amp_total;
			f.difference_sum = diff_total;
			f.sample_count = seen;
			f.zero_crossings = crossings;
			f.burst_count = bursts;
			f.short_burst_count = short_bursts;
			f.long_burst_count = long_bursts;
			pending_windows.push_back(f);
			open_window();
		end
	endfunction

	task report(string msg);
		mismatch_count++;
		$display("%0t mismatch: %s", $realtime, msg);
	endtask

	task check_field(string name, logic [31:0] got, logic [31:0] want);
		if (got !== want)
			report($sformatf("%s got %0d want %0d", name, got, want));
	endtask

	task compare_features(window_features_t got);
		window_features_t want;
		if (pending_windows.size() == 0) begin
			report($sformatf("result with no window pending, sample_count %0d",
				got.sample_count));
			return;
		end
		want = pending_windows.pop_front();
		check_field("peak_to_peak", got.peak_to_peak, want.peak_to_peak);
		check_field("amplitude_sum", got.amplitude_sum, want.amplitude_sum);
		check_field("difference_sum", got.difference_sum, want.difference_sum);
		check_field("sample_count", got.sample_count, want.sample_count);
		check_field("zero_crossings", got.zero_crossings, want.zero_crossings);
		check_field("burst_count", got.burst_count, want.burst_count);
		check_field("short_burst_count", got.short_burst_count, want.short_burst_count);
		check_field("long_burst_count", got.long_burst_count, want.long_burst_count);
	endtask
endclass

module audio_window_feature_extractor_core_test;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [THR_W-1:0]   cfg_wdata;
	logic               in_valid;
	logic               in_stall;
	logic [RAW_W-1:0]   sample;
	logic               last_of_window;
	logic               out_valid;
	logic               out_stall;
	logic [RAW_W-1:0]   peak_to_peak;
	logic [SUM_W-1:0]   amplitude_sum;
	logic [SUM_W-1:0]   difference_sum;
	logic [CNT_W-1:0]   sample_count;
	logic [CROSS_W-1:0] zero_crossings;
	logic [TOT_W-1:0]   burst_count;
	logic [SHORT_W-1:0] short_burst_count;
	logic [LONG_W-1:0]  long_burst_count;

	window_feature_board board;
	int sender_idle_pct = 0;
	int stall_pct = 0;
	int stall_hold = 0;

	logic [RAW_W:0] opening_items [22] = '{
		{1'b1, 10'd0},
		{1'b0, 10'd1023}, {1'b0, 10'd1023}, {1'b0, 10'd512}, {1'b0, 10'd531},
		{1'b0, 10'd0}, {1'b0, 10'd530}, {1'b0, 10'd493}, {1'b0, 10'd493},
		{1'b0, 10'd493}, {1'b0, 10'd493}, {1'b0, 10'd493}, {1'b1, 10'd512},
		{1'b0, 10'd531}, {1'b0, 10'd512}, {1'b0, 10'd400}, {1'b0, 10'd300},
		{1'b1, 10'd200},
		{1'b0, 10'd0}, {1'b0, 10'd1023}, {1'b0, 10'd0}, {1'b1, 10'd1023}
	};

	audio_window_feature_extractor_core dut (.*);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_hold > 0) begin
				out_stall = 1'b1;
				stall_hold--;
			end else begin
				out_stall = ($urandom_range(99) < stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_stall == 1'b0)
			board.compare_features('{peak_to_peak, amplitude_sum, difference_sum,
				sample_count, zero_crossings, burst_count, short_burst_count,
				long_burst_count});
	end

	function automatic logic [RAW_W-1:0] to_raw(int mag, bit neg);
		if (neg)
			return RAW_W'(512 - mag);
		return RAW_W'(512 + ((mag > 511) ? 511 : mag));
	endfunction

	function automatic logic [RAW_W-1:0] loud(int thr, bit neg);
		return to_raw($urandom_range(512, thr + 1), neg);
	endfunction

	function automatic logic [RAW_W-1:0] pick_sample(int thr);
		int mag;
		case ($urandom_range(4))
			0: return RAW_W'($urandom_range(1023));
			1: begin
				mag = thr - 1 + $urandom_range(2);
				return to_raw((mag < 0) ? 0 : mag, $urandom_range(1));
			end
			2: begin
				case ($urandom_range(4))
					0: return RAW_W'(0);
					1: return RAW_W'(1023);
					2: return RAW_W'(511);
					3: return RAW_W'(513);
					default: return MIDPOINT;
				endcase
			end
			3: return RAW_W'(508 + $urandom_range(8));
			default: return loud(thr, $urandom_range(1));
		endcase
	endfunction

	task automatic send_sample(input logic [RAW_W-1:0] s, input logic last);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		sample = s;
		last_of_window = last;
		do
			@(posedge clk);
		while (in_stall);
		board.take_sample(s, last);
		@(negedge clk);
	endtask

	task automatic settle();
		in_valid = 1'b0;
		while (board.pending_windows.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_threshold(input logic [THR_W-1:0] v);
		cfg_we = 1'b1;
		cfg_wdata = v;
		@(negedge clk);
		cfg_we = 1'b0;
		board.threshold = v;
	endtask

	task automatic send_random_window(input int len);
		int n;
		int k;
		int thr;
		thr = board.threshold;
		n = 0;
		while (n < len) begin
			if ($urandom_range(2) == 0) begin
				k = $urandom_range(7, 1);
				for (int j = 0; j < k && n < len; j++) begin
					send_sample(loud(thr, $urandom_range(1)), n == len - 1);
					n++;
				end
			end else begin
				send_sample(pick_sample(thr), n == len - 1);
				n++;
			end
		end
	endtask

	task automatic run_phase(input int thr, input int idle, input int stall,
		input int items, input int max_len);
		int sent;
		int len;
		int r;
		settle();
		write_threshold(thr);
		sender_idle_pct = idle;
		stall_pct = stall;
		sent = 0;
		while (sent < items) begin
			r = $urandom_range(99);
			if (r < 10 || max_len < 41)
				len = $urandom_range(max_len, 1);
			else if (r < 85)
				len = $urandom_range(40, 2);
			else
				len = $urandom_range(max_len, 41);
			send_random_window(len);
			sent += len;
		end
	endtask

	initial begin
		board = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		sample = '0;
		last_of_window = 1'b0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (opening_items[i])
			send_sample(opening_items[i][RAW_W-1:0], opening_items[i][RAW_W]);

		run_phase(70, 0, 0, 380, 300);
		run_phase(0, 67, 0, 380, 300);
		run_phase(127, 0, 67, 380, 300);
		run_phase($urandom_range(69, 19), 25, 25, 380, 300);

		// hold the output long enough for the queue to fill and stall the input
		settle();
		stall_hold = 400;
		run_phase(18, 0, 0, 200, 4);

		stall_pct = 0;
		settle();
		repeat (10) @(negedge clk);
		if (board.mismatch_count == 0)
			$display("audio_window_feature_extractor_core_test OK");
		else
			$display("audio_window_feature_extractor_core_test NOT OK");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("audio_window_feature_extractor_core_test NOT OK");
		$finish;
	end

endmodule
